// ----- hdl/gtms_pkg.sv -----
// Shared constants and types for the glyph table match search unit.
package gtms_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;

    localparam int INDEX_W     = 9;
    localparam int CHAR_W      = 8;
    localparam int STYLE_W     = 8;
    localparam int ENTRY_W     = 3 * CHAR_W + STYLE_W;

    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 16;

    // Item kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Style codes
    localparam logic [STYLE_W-1:0] STYLE_ROMAN      = 8'd0;
    localparam logic [STYLE_W-1:0] STYLE_SMALL_CAPS = 8'd2;
    localparam logic [STYLE_W-1:0] STYLE_SPECIAL    = 8'd3;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [CHAR_W-1:0] CHAR_PERIOD  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_HYPHEN  = 8'h2D;

    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = COUNT_W'(272);

    typedef struct packed {
        logic [STYLE_W-1:0] style;
        logic [CHAR_W-1:0]  c2;
        logic [CHAR_W-1:0]  c1;
        logic [CHAR_W-1:0]  c0;
    } glyph_entry_t;

    // Normalize the requested style of a lookup.
    function automatic logic [STYLE_W-1:0] norm_style(
        input logic [CHAR_W-1:0]  c0,
        input logic [CHAR_W-1:0]  c1,
        input logic [STYLE_W-1:0] st
    );
        logic [STYLE_W-1:0] s;
        s = st;
        if (s == STYLE_SMALL_CAPS && (c0 < CHAR_LOWER_A || c0 > CHAR_LOWER_Z))
        begin
            s = STYLE_ROMAN;
        end
        if (c0 != CHAR_NONE && c1 == CHAR_NONE
            && (c0 == CHAR_PERIOD || c0 == CHAR_HYPHEN) && s != STYLE_SPECIAL)
        begin
            s = STYLE_ROMAN;
        end
        return s;
    endfunction

endpackage

// ----- hdl/glyph_table_match_search_unit.sv -----
// Glyph table with a sequential lowest-index match search over one memory.
//
//  channel | dir | signals                          | carries
//  --------+-----+----------------------------------+------------------------------
//  s_*     | in  | s_tvalid s_tready s_tdata s_tuser| write or lookup word
//  m_*     | out | m_tvalid m_tready m_tdata m_tuser| found flag and match index
//  cfg_*   | in  | cfg_valid cfg_ready cfg_data     | entry_count register
//
// A lookup scans entries 0 to limit - 1, where limit is entry_count clamped to
// 1..TABLE_DEPTH: the scan reads one table entry per cycle through the single
// synchronous read port and compares it in the next cycle, stopping at the first hit.
// Reset clears control state and loads entry_count with 272; the table needs no
// clearing pass. The output register holds a result while m_tready is low, and the
// unit still takes the next input word; it stalls during a scan and while a new result waits.
module glyph_table_match_search_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gtms_pkg::S_TDATA_W-1:0]   s_tdata,  // entry_index[8:0], char_first,
                                                       // char_second, char_third,
                                                       // style_code, zero pad
    input  logic                             s_tuser,  // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gtms_pkg::M_TDATA_W-1:0]   m_tdata,  // match_index[8:0], zero pad
    output logic                             m_tuser,  // found
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gtms_pkg::COUNT_W-1:0]     cfg_data   // entry_count
);
    import gtms_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  entry_count_reg;
    logic [COUNT_W-1:0]  limit_reg, limit_next;
    logic [COUNT_W-1:0]  iss_cnt_reg, iss_cnt_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                chk_last_reg, chk_last_next;
    logic [ADDR_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [CHAR_W-1:0]   q_c0_reg, q_c0_next;
    logic [CHAR_W-1:0]   q_c1_reg, q_c1_next;
    logic [CHAR_W-1:0]   q_c2_reg, q_c2_next;
    logic [STYLE_W-1:0]  q_style_reg, q_style_next;
    logic                res_found_reg, res_found_next;
    logic [INDEX_W-1:0]  res_idx_reg, res_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic [INDEX_W-1:0]  out_idx_reg, out_idx_next;

    glyph_entry_t        mem [TABLE_DEPTH];
    glyph_entry_t        rd_data_reg;
    glyph_entry_t        wr_data;
    logic                mem_we;
    logic                issue;

    logic                in_fire;
    logic [INDEX_W-1:0]  in_index;
    logic [CHAR_W-1:0]   in_c0, in_c1, in_c2;
    logic [STYLE_W-1:0]  in_style;
    logic                hit;
    logic                out_free;

    assign in_index = s_tdata[8:0];
    assign in_c0    = s_tdata[16:9];
    assign in_c1    = s_tdata[24:17];
    assign in_c2    = s_tdata[32:25];
    assign in_style = s_tdata[40:33];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign mem_we    = in_fire && (s_tuser == KIND_WRITE);
    assign wr_data   = '{style: in_style, c2: in_c2, c1: in_c1, c0: in_c0};
    assign issue     = (state_reg == ST_SCAN) && (iss_cnt_reg < limit_reg);
    assign out_free  = !out_valid_reg || m_tready;

    assign hit = (q_c0_reg == CHAR_NONE
                  || (rd_data_reg.c0 == q_c0_reg && rd_data_reg.c1 == q_c1_reg
                      && rd_data_reg.c2 == q_c2_reg))
                 && rd_data_reg.style == q_style_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {{(M_TDATA_W - INDEX_W){1'b0}}, out_idx_reg};

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[in_index[ADDR_W-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[iss_cnt_reg[ADDR_W-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        iss_cnt_next   = iss_cnt_reg;
        rd_pend_next   = 1'b0;
        chk_last_next  = chk_last_reg;
        chk_idx_next   = chk_idx_reg;
        q_c0_next      = q_c0_reg;
        q_c1_next      = q_c1_reg;
        q_c2_next      = q_c2_reg;
        q_style_next   = q_style_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_idx_next   = out_idx_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_found_next = 1'b0;
                    res_idx_next   = '0;
                    if (s_tuser == KIND_LOOKUP)
                    begin
                        q_c0_next    = in_c0;
                        q_c1_next    = in_c1;
                        q_c2_next    = in_c2;
                        q_style_next = norm_style(in_c0, in_c1, in_style);
                        iss_cnt_next = '0;
                        if (entry_count_reg == '0)
                        begin
                            limit_next = COUNT_W'(1);
                        end
                        else if (entry_count_reg > COUNT_W'(TABLE_DEPTH))
                        begin
                            limit_next = COUNT_W'(TABLE_DEPTH);
                        end
                        else
                        begin
                            limit_next = entry_count_reg;
                        end
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue the next read while checking the entry read last cycle.
                if (issue)
                begin
                    rd_pend_next  = 1'b1;
                    chk_idx_next  = iss_cnt_reg[ADDR_W-1:0];
                    chk_last_next = (iss_cnt_reg + COUNT_W'(1)) == limit_reg;
                    iss_cnt_next  = iss_cnt_reg + COUNT_W'(1);
                end
                if (rd_pend_reg)
                begin
                    if (hit)
                    begin
                        res_found_next = 1'b1;
                        res_idx_next   = INDEX_W'(chk_idx_reg);
                        rd_pend_next   = 1'b0;
                        state_next     = ST_DONE;
                    end
                    else if (chk_last_reg)
                    begin
                        rd_pend_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_idx_next   = res_idx_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= ENTRY_COUNT_RESET;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                entry_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg     <= limit_next;
        iss_cnt_reg   <= iss_cnt_next;
        chk_last_reg  <= chk_last_next;
        chk_idx_reg   <= chk_idx_next;
        q_c0_reg      <= q_c0_next;
        q_c1_reg      <= q_c1_next;
        q_c2_reg      <= q_c2_next;
        q_style_reg   <= q_style_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        out_found_reg <= out_found_next;
        out_idx_reg   <= out_idx_next;
    end

endmodule
